### rtl/max_tracking_queue_core_defines.svh
// ----------------------------------------------------------------------------
// max_tracking_queue_core assertion macros
// Shared property wrappers, clocked on i_clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef MAX_TRACKING_QUEUE_CORE_DEFINES_SVH
`define MAX_TRACKING_QUEUE_CORE_DEFINES_SVH

// same-cycle implication
`define MTQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("max_tracking_queue_core: check failed");

// next-cycle implication
`define MTQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("max_tracking_queue_core: check failed");

`endif

### rtl/mtq_pkg.sv
// ----------------------------------------------------------------------------
// mtq_pkg
// Sizes, codes and shared types of the max-tracking two-stack queue.
// ----------------------------------------------------------------------------
package mtq_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH);
    localparam int WORD_W      = 32;
    localparam int COUNT_W     = DEPTH_W + 2;

    typedef logic [DEPTH_W-1:0]       t_addr;
    typedef logic [DEPTH_W:0]         t_depth;
    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        REQ_ENQ = 2'd0,
        REQ_DEQ = 2'd1,
        REQ_QRY = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MOVE,
        S_POP,
        S_REFILL,
        S_DONE
    } t_state;

    // one stack entry: the word and the running maximum up to it
    typedef struct packed {
        t_word word;
        t_word maxv;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_addr  addr;
        t_entry data;
    } t_ram_wr;

    typedef struct packed {
        t_word                popped;
        t_word                head;
        t_word                tail;
        t_word                maxv;
        logic [COUNT_W-1:0]   count;
        t_status              status;
    } t_result;

endpackage

### rtl/max_tracking_queue_core.sv
// ----------------------------------------------------------------------------
// max_tracking_queue_core
// FIFO of signed words built from an input and an output stack, each entry
// carrying the running maximum, reporting head, tail, maximum and count.
// Sequence: enqueue and query pass through execute and done; a dequeue adds
// a stack-top reload when two or more output entries were held, or, when the
// output stack is empty, walks the input entries across, one per cycle, then
// pops and reloads the top (no reload when only one entry was walked).
// A new item is accepted only once the previous result enters the output stage.
// Reset: synchronous, active low; empties both stacks, no memory sweep.
// ----------------------------------------------------------------------------
module max_tracking_queue_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_req_type,
    input  logic signed [31:0]           i_value_in,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [31:0]           o_popped_value,
    output logic signed [31:0]           o_head_value,
    output logic signed [31:0]           o_tail_value,
    output logic signed [31:0]           o_max_value,
    output logic [mtq_pkg::COUNT_W-1:0]  o_entry_count,
    output logic [1:0]                   o_status
);

    mtq_pkg::t_ram_wr in_wr, out_wr;
    mtq_pkg::t_addr   in_raddr, out_raddr;
    mtq_pkg::t_entry  in_rdata, out_rdata;
    mtq_pkg::t_result res;
    logic             res_valid;
    logic             take;
    logic             r_o_valid;
    mtq_pkg::t_result r_res;

    // output stage frees up when empty or when its item leaves this cycle
    assign take = res_valid && (!r_o_valid || i_ready);

    mtq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_value_in  (i_value_in),
        .o_res_valid (res_valid),
        .i_take      (take),
        .o_res       (res),
        .o_in_wr     (in_wr),
        .o_in_raddr  (in_raddr),
        .i_in_rdata  (in_rdata),
        .o_out_wr    (out_wr),
        .o_out_raddr (out_raddr),
        .i_out_rdata (out_rdata)
    );

    mtq_stack_ram u_in_ram (
        .i_clk   (i_clk),
        .i_wr    (in_wr),
        .i_raddr (in_raddr),
        .o_rdata (in_rdata)
    );

    mtq_stack_ram u_out_ram (
        .i_clk   (i_clk),
        .i_wr    (out_wr),
        .i_raddr (out_raddr),
        .o_rdata (out_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (take) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= res;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_popped_value = r_res.popped;
    assign o_head_value   = r_res.head;
    assign o_tail_value   = r_res.tail;
    assign o_max_value    = r_res.maxv;
    assign o_entry_count  = r_res.count;
    assign o_status       = r_res.status;

endmodule

### rtl/mtq_stack_ram.sv
// ----------------------------------------------------------------------------
// mtq_stack_ram
// One stack store: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module mtq_stack_ram (
    input  logic             i_clk,
    input  mtq_pkg::t_ram_wr i_wr,
    input  mtq_pkg::t_addr   i_raddr,
    output mtq_pkg::t_entry  o_rdata
);

    mtq_pkg::t_entry r_mem [mtq_pkg::STACK_DEPTH];
    mtq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mtq_ctrl.sv
// ----------------------------------------------------------------------------
// mtq_ctrl
// Request sequencer: stack depths, cached stack tops and bottoms, the
// transfer walk from the input stack to the output stack, result build.
// ----------------------------------------------------------------------------
module mtq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_req_type,
    input  mtq_pkg::t_word   i_value_in,
    output logic             o_res_valid,
    input  logic             i_take,
    output mtq_pkg::t_result o_res,
    output mtq_pkg::t_ram_wr o_in_wr,
    output mtq_pkg::t_addr   o_in_raddr,
    input  mtq_pkg::t_entry  i_in_rdata,
    output mtq_pkg::t_ram_wr o_out_wr,
    output mtq_pkg::t_addr   o_out_raddr,
    input  mtq_pkg::t_entry  i_out_rdata
);

    mtq_pkg::t_state  r_state, n_state;
    logic [1:0]       r_req, n_req;
    mtq_pkg::t_word   r_x, n_x;
    mtq_pkg::t_depth  r_in_depth, n_in_depth;
    mtq_pkg::t_depth  r_out_depth, n_out_depth;
    mtq_pkg::t_word   r_in_top_w, n_in_top_w;
    mtq_pkg::t_word   r_in_top_m, n_in_top_m;
    mtq_pkg::t_word   r_in_bot_w, n_in_bot_w;
    mtq_pkg::t_word   r_out_top_w, n_out_top_w;
    mtq_pkg::t_word   r_out_top_m, n_out_top_m;
    mtq_pkg::t_word   r_out_bot_w, n_out_bot_w;
    mtq_pkg::t_word   r_popped, n_popped;
    mtq_pkg::t_status r_status, n_status;

    logic            accept;
    logic            in_empty, out_empty, in_full;
    mtq_pkg::t_depth in_last, out_below;
    mtq_pkg::t_word  enq_max, mv_w, mv_max;

    assign in_empty  = (r_in_depth == '0);
    assign out_empty = (r_out_depth == '0);
    assign in_full   = (r_in_depth == mtq_pkg::t_depth'(mtq_pkg::STACK_DEPTH));
    assign in_last   = r_in_depth - mtq_pkg::t_depth'(1);
    assign out_below = r_out_depth - mtq_pkg::t_depth'(2);

    assign o_ready = (r_state == mtq_pkg::S_IDLE) || (r_state == mtq_pkg::S_DONE && i_take);
    assign accept  = i_valid && o_ready;

    assign enq_max = (in_empty || r_x > r_in_top_m) ? r_x : r_in_top_m;
    assign mv_w    = i_in_rdata.word;
    assign mv_max  = (out_empty || mv_w > r_out_top_m) ? mv_w : r_out_top_m;

    // read ports sit on the next entry that may be needed
    assign o_in_raddr  = in_last[mtq_pkg::DEPTH_W-1:0];
    assign o_out_raddr = out_below[mtq_pkg::DEPTH_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = mtq_pkg::S_EXEC;
                end
            end
            mtq_pkg::S_EXEC: begin
                case (r_req)
                    mtq_pkg::REQ_ENQ: n_state = mtq_pkg::S_DONE;
                    mtq_pkg::REQ_DEQ: begin
                        if (out_empty && in_empty) begin
                            n_state = mtq_pkg::S_DONE;
                        end else if (out_empty) begin
                            n_state = mtq_pkg::S_MOVE;
                        end else if (r_out_depth >= mtq_pkg::t_depth'(2)) begin
                            n_state = mtq_pkg::S_REFILL;
                        end else begin
                            n_state = mtq_pkg::S_DONE;
                        end
                    end
                    default: n_state = mtq_pkg::S_DONE;
                endcase
            end
            mtq_pkg::S_MOVE: begin
                if (in_empty) begin
                    n_state = mtq_pkg::S_POP;
                end
            end
            mtq_pkg::S_POP: begin
                if (r_out_depth >= mtq_pkg::t_depth'(2)) begin
                    n_state = mtq_pkg::S_REFILL;
                end else begin
                    n_state = mtq_pkg::S_DONE;
                end
            end
            mtq_pkg::S_REFILL: n_state = mtq_pkg::S_DONE;
            mtq_pkg::S_DONE: begin
                if (i_take) begin
                    n_state = i_valid ? mtq_pkg::S_EXEC : mtq_pkg::S_IDLE;
                end
            end
            default: n_state = mtq_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_req       = accept ? i_req_type : r_req;
        n_x         = accept ? i_value_in : r_x;
        n_in_depth  = r_in_depth;
        n_out_depth = r_out_depth;
        n_in_top_w  = r_in_top_w;
        n_in_top_m  = r_in_top_m;
        n_in_bot_w  = r_in_bot_w;
        n_out_top_w = r_out_top_w;
        n_out_top_m = r_out_top_m;
        n_out_bot_w = r_out_bot_w;
        n_popped    = r_popped;
        n_status    = r_status;

        o_in_wr.we        = 1'b0;
        o_in_wr.addr      = r_in_depth[mtq_pkg::DEPTH_W-1:0];
        o_in_wr.data.word = r_x;
        o_in_wr.data.maxv = enq_max;

        o_out_wr.we        = 1'b0;
        o_out_wr.addr      = r_out_depth[mtq_pkg::DEPTH_W-1:0];
        o_out_wr.data.word = mv_w;
        o_out_wr.data.maxv = mv_max;

        case (r_state)
            mtq_pkg::S_EXEC: begin
                n_popped = '0;
                n_status = mtq_pkg::ST_OK;
                case (r_req)
                    mtq_pkg::REQ_ENQ: begin
                        if (in_full) begin
                            n_status = mtq_pkg::ST_OVER;
                        end else begin
                            o_in_wr.we = 1'b1;
                            n_in_depth = r_in_depth + mtq_pkg::t_depth'(1);
                            n_in_top_w = r_x;
                            n_in_top_m = enq_max;
                            if (in_empty) begin
                                n_in_bot_w = r_x;
                            end
                        end
                    end
                    mtq_pkg::REQ_DEQ: begin
                        if (out_empty && in_empty) begin
                            n_status = mtq_pkg::ST_UNDER;
                        end else if (out_empty) begin
                            // first read of the walk is under way on the in port
                            n_in_depth = in_last;
                        end else begin
                            n_popped    = r_out_top_w;
                            n_out_depth = r_out_depth - mtq_pkg::t_depth'(1);
                        end
                    end
                    default: begin
                        if (out_empty && in_empty) begin
                            n_status = mtq_pkg::ST_UNDER;
                        end
                    end
                endcase
            end
            mtq_pkg::S_MOVE: begin
                // push the word that arrived, issue the next read if any remain
                o_out_wr.we = 1'b1;
                n_out_depth = r_out_depth + mtq_pkg::t_depth'(1);
                n_out_top_w = mv_w;
                n_out_top_m = mv_max;
                if (out_empty) begin
                    n_out_bot_w = mv_w;
                end
                if (!in_empty) begin
                    n_in_depth = in_last;
                end
            end
            mtq_pkg::S_POP: begin
                n_popped    = r_out_top_w;
                n_out_depth = r_out_depth - mtq_pkg::t_depth'(1);
            end
            mtq_pkg::S_REFILL: begin
                n_out_top_w = i_out_rdata.word;
                n_out_top_m = i_out_rdata.maxv;
            end
            default: begin
            end
        endcase
    end

    // result from the cached tops and bottoms
    always_comb begin
        o_res_valid   = (r_state == mtq_pkg::S_DONE);
        o_res.popped  = r_popped;
        o_res.status  = r_status;
        o_res.count   = mtq_pkg::COUNT_W'(r_in_depth) + mtq_pkg::COUNT_W'(r_out_depth);
        o_res.head    = !out_empty ? r_out_top_w : (!in_empty ? r_in_bot_w : '0);
        o_res.tail    = !in_empty ? r_in_top_w : (!out_empty ? r_out_bot_w : '0);
        if (!in_empty && !out_empty) begin
            o_res.maxv = (r_in_top_m > r_out_top_m) ? r_in_top_m : r_out_top_m;
        end else if (!in_empty) begin
            o_res.maxv = r_in_top_m;
        end else if (!out_empty) begin
            o_res.maxv = r_out_top_m;
        end else begin
            o_res.maxv = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtq_pkg::S_IDLE;
            r_in_depth  <= '0;
            r_out_depth <= '0;
        end else begin
            r_state     <= n_state;
            r_in_depth  <= n_in_depth;
            r_out_depth <= n_out_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_x         <= n_x;
        r_in_top_w  <= n_in_top_w;
        r_in_top_m  <= n_in_top_m;
        r_in_bot_w  <= n_in_bot_w;
        r_out_top_w <= n_out_top_w;
        r_out_top_m <= n_out_top_m;
        r_out_bot_w <= n_out_bot_w;
        r_popped    <= n_popped;
        r_status    <= n_status;
    end

endmodule

### rtl/mtq_checker.sv
// ----------------------------------------------------------------------------
// mtq_checker
// Port-level checks on the queue results, bound to the top level.
// ----------------------------------------------------------------------------
`include "max_tracking_queue_core_defines.svh"

module mtq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic [1:0]                   i_req_type,
    input logic signed [31:0]           i_value_in,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic signed [31:0]           o_popped_value,
    input logic signed [31:0]           o_head_value,
    input logic signed [31:0]           o_tail_value,
    input logic signed [31:0]           o_max_value,
    input logic [mtq_pkg::COUNT_W-1:0]  o_entry_count,
    input logic [1:0]                   o_status
);

    // an empty queue reports zero head, tail and maximum
    `MTQ_ASSERT_IMP(a_empty_zero, o_valid && o_entry_count == '0, o_head_value == '0 && o_tail_value == '0 && o_max_value == '0)

    // underflow only on an empty queue, and nothing is popped
    `MTQ_ASSERT_IMP(a_underflow, o_valid && o_status == mtq_pkg::ST_UNDER, o_entry_count == '0 && o_popped_value == '0)

    // overflow only with at least STACK_DEPTH entries queued, and nothing is popped
    `MTQ_ASSERT_IMP(a_overflow, o_valid && o_status == mtq_pkg::ST_OVER, o_entry_count >= mtq_pkg::COUNT_W'(mtq_pkg::STACK_DEPTH) && o_popped_value == '0)

    // a single word is head, tail and maximum at once
    `MTQ_ASSERT_IMP(a_single, o_valid && o_entry_count == mtq_pkg::COUNT_W'(1), o_head_value == o_tail_value && o_max_value == o_head_value)

    // a stalled result holds
    `MTQ_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_max_value) && $stable(o_entry_count))

endmodule

bind max_tracking_queue_core mtq_checker u_mtq_checker (.*);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for max_tracking_queue_core. A clocked driver offers
// enqueue, dequeue and query items from a pending list, and a shadow copy of
// the two stacks predicts each result. A clocked monitor compares every
// result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mtq_pkg::*;

    // request code three is unused and behaves as a query
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_PCT     = 21;
    localparam int STEADY_FROM  = 1000;
    localparam int STEADY_TO    = 1300;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_LEN     = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [1:0] req;
        t_word      value;
    } t_request;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic [1:0]            i_req_type = REQ_QRY;
    logic signed [31:0]    i_value_in = '0;
    logic                  i_ready    = 1'b0;
    logic                  o_ready;
    logic                  o_valid;
    logic signed [31:0]    o_popped_value;
    logic signed [31:0]    o_head_value;
    logic signed [31:0]    o_tail_value;
    logic signed [31:0]    o_max_value;
    logic [COUNT_W-1:0]    o_entry_count;
    logic [1:0]            o_status;

    t_request pending_requests[$];
    t_request next_request;
    t_result  expected_snapshots[$];
    t_result  seen_snapshot;

    // shadow of the queue state
    t_word shadow_in_words  [STACK_DEPTH];
    t_word shadow_in_maxima [STACK_DEPTH];
    t_word shadow_out_words [STACK_DEPTH];
    t_word shadow_out_maxima[STACK_DEPTH];
    int    shadow_in_depth  = 0;
    int    shadow_out_depth = 0;

    int cycle_count  = 0;
    int results_seen = 0;
    int hold_cycles  = 0;
    bit hold_done    = 1'b0;
    int error_count  = 0;

    max_tracking_queue_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_value_in     (i_value_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_popped_value (o_popped_value),
        .o_head_value   (o_head_value),
        .o_tail_value   (o_tail_value),
        .o_max_value    (o_max_value),
        .o_entry_count  (o_entry_count),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic bit in_steady_stretch();
        return (cycle_count >= STEADY_FROM) && (cycle_count < STEADY_TO);
    endfunction

    function automatic bit take_break();
        return !in_steady_stretch() && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // running maximum of a stack after pushing x onto an entry of depth d
    function automatic t_word running_max(int d, t_word below, t_word x);
        if (d == 0 || x > below) begin
            return x;
        end
        return below;
    endfunction

    task automatic predict_queue_step(input logic [1:0] req, input t_word value);
        t_result snap;
        t_word   moved;
        snap        = '0;
        snap.status = ST_OK;
        case (req)
            REQ_ENQ: begin
                if (shadow_in_depth >= STACK_DEPTH) begin
                    snap.status = ST_OVER;
                end else begin
                    shadow_in_words[shadow_in_depth]  = value;
                    shadow_in_maxima[shadow_in_depth] = running_max(shadow_in_depth,
                        (shadow_in_depth > 0) ? shadow_in_maxima[shadow_in_depth-1] : '0,
                        value);
                    shadow_in_depth++;
                end
            end
            REQ_DEQ: begin
                if (shadow_in_depth == 0 && shadow_out_depth == 0) begin
                    snap.status = ST_UNDER;
                end else begin
                    // refill: move the input stack across, newest first
                    if (shadow_out_depth == 0) begin
                        while (shadow_in_depth > 0) begin
                            shadow_in_depth--;
                            moved = shadow_in_words[shadow_in_depth];
                            shadow_out_words[shadow_out_depth]  = moved;
                            shadow_out_maxima[shadow_out_depth] = running_max(
                                shadow_out_depth,
                                (shadow_out_depth > 0) ?
                                    shadow_out_maxima[shadow_out_depth-1] : '0,
                                moved);
                            shadow_out_depth++;
                        end
                    end
                    shadow_out_depth--;
                    snap.popped = shadow_out_words[shadow_out_depth];
                end
            end
            default: begin
                if (shadow_in_depth == 0 && shadow_out_depth == 0) begin
                    snap.status = ST_UNDER;
                end
            end
        endcase

        if (shadow_out_depth > 0) begin
            snap.head = shadow_out_words[shadow_out_depth-1];
        end else if (shadow_in_depth > 0) begin
            snap.head = shadow_in_words[0];
        end

        if (shadow_in_depth > 0) begin
            snap.tail = shadow_in_words[shadow_in_depth-1];
        end else if (shadow_out_depth > 0) begin
            snap.tail = shadow_out_words[0];
        end

        if (shadow_in_depth > 0 && shadow_out_depth > 0) begin
            snap.maxv = (shadow_in_maxima[shadow_in_depth-1] >
                         shadow_out_maxima[shadow_out_depth-1]) ?
                        shadow_in_maxima[shadow_in_depth-1] :
                        shadow_out_maxima[shadow_out_depth-1];
        end else if (shadow_in_depth > 0) begin
            snap.maxv = shadow_in_maxima[shadow_in_depth-1];
        end else if (shadow_out_depth > 0) begin
            snap.maxv = shadow_out_maxima[shadow_out_depth-1];
        end

        snap.count = COUNT_W'(shadow_in_depth + shadow_out_depth);
        expected_snapshots.push_back(snap);
    endtask

    function automatic void add_request(logic [1:0] req, t_word value);
        t_request r;
        r.req   = req;
        r.value = value;
        pending_requests.push_back(r);
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(0, 4))
            0:       return t_word'($urandom_range(0, 20)) - 10;
            1:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2:       return t_word'($urandom_range(0, 1000));
            default: return t_word'($urandom());
        endcase
    endfunction

    function automatic logic [1:0] pick_request();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            return REQ_ENQ;
        end else if (roll < 85) begin
            return REQ_DEQ;
        end else if (roll < 95) begin
            return REQ_QRY;
        end
        return REQ_SPARE;
    endfunction

    task automatic check_field(input string field, input t_word want, input t_word got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            error_count++;
        end
    endtask

    // driver: hold the item until accepted, then advance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_queue_step(i_req_type, i_value_in);
            end
            if (!i_valid || o_ready) begin
                if (pending_requests.size() != 0 && !take_break()) begin
                    next_request = pending_requests.pop_front();
                    i_valid    <= 1'b1;
                    i_req_type <= next_request.req;
                    i_value_in <= next_request.value;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each item against the oldest prediction, drive ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_snapshots.size() == 0) begin
                    $error("result item with no prediction waiting");
                    error_count++;
                end else begin
                    seen_snapshot = expected_snapshots.pop_front();
                    check_field("popped_value", seen_snapshot.popped, o_popped_value);
                    check_field("head_value", seen_snapshot.head, o_head_value);
                    check_field("tail_value", seen_snapshot.tail, o_tail_value);
                    check_field("max_value", seen_snapshot.maxv, o_max_value);
                    check_field("entry_count", t_word'(seen_snapshot.count),
                                t_word'(o_entry_count));
                    check_field("status", t_word'(seen_snapshot.status),
                                t_word'(o_status));
                end
            end
            // one long hold-off so that the block backs up onto its input
            if (hold_cycles != 0) begin
                hold_cycles--;
                i_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done   = 1'b1;
                hold_cycles = HOLD_LEN;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !take_break();
            end
        end
    end

    initial begin
        int made;
        int burst;
        int pattern;

        // empty queue cases, including the spare code
        add_request(REQ_QRY, 32'h1234_5678);
        add_request(REQ_DEQ, 32'hFFFF_FFFF);
        add_request(REQ_SPARE, 32'h8000_0000);
        // fill the input stack, extremes first, then one enqueue too many
        add_request(REQ_ENQ, 32'h8000_0000);
        add_request(REQ_ENQ, 32'h7FFF_FFFF);
        add_request(REQ_ENQ, 32'hFFFF_FFFF);
        add_request(REQ_ENQ, 32'h0000_0000);
        for (int k = 4; k < STACK_DEPTH; k++) begin
            add_request(REQ_ENQ, pick_word());
        end
        add_request(REQ_ENQ, 32'h0000_0001);
        // dequeue through a full refill, then queries and a mixed state
        add_request(REQ_DEQ, 32'h5555_5555);
        add_request(REQ_QRY, 32'hAAAA_AAAA);
        add_request(REQ_SPARE, 32'h0);
        add_request(REQ_ENQ, 32'h7FFF_FFFF);
        add_request(REQ_DEQ, 32'h0);

        made = 0;
        while (made < RANDOM_ITEMS) begin
            pattern = $urandom_range(0, 9);
            if (pattern < 3) begin
                burst = $urandom_range(8, 20);
                repeat (burst) add_request(REQ_ENQ, pick_word());
            end else if (pattern < 5) begin
                burst = $urandom_range(4, 20);
                repeat (burst) add_request(REQ_DEQ, t_word'($urandom()));
            end else if (pattern < 9) begin
                burst = $urandom_range(1, 8);
                repeat (burst) add_request(pick_request(), pick_word());
            end else begin
                burst = 1;
                add_request(2'($urandom_range(0, 3)), t_word'($urandom()));
            end
            made += burst;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (expected_snapshots.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_snapshots.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/mtq_pkg.sv
rtl/mtq_stack_ram.sv
rtl/mtq_ctrl.sv
rtl/max_tracking_queue_core.sv
rtl/mtq_checker.sv
sim/tb_top.sv
